FILE: sv/srsd_pkg.sv
// ----------------------------------------------------------------------------
// srsd_pkg: shared types and constants of the raster stream decoder
// Result and queue entry layouts, result codes, register indexes and limits.
// ----------------------------------------------------------------------------
`default_nettype none

package srsd_pkg;

   // Limits and file constants
   localparam int unsigned DIM_W      = 15;
   localparam logic [31:0] MAX_DIM    = 32'd16384;
   localparam logic [31:0] RAS_MAGIC  = 32'h59a66a95;
   localparam logic [5:0]  DEPTH_CLIP = 6'd63;
   localparam logic [7:0]  ALPHA_FULL = 8'd255;
   localparam logic [4:0]  HDR_LAST   = 5'd31;

   // Result queue
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QADDR_W     = $clog2(QUEUE_DEPTH);

   // Result kinds
   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_INFO   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // Final status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TRUNCATED = 3'd1;
   localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
   localparam logic [2:0] ST_BAD_DIMS  = 3'd3;
   localparam logic [2:0] ST_UNSUPP    = 3'd4;

   // Configuration register indexes
   localparam logic [1:0] CSR_MAX_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_MAX_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_HEADER_ONLY = 2'd2;

   localparam logic [DIM_W-1:0] MAX_DIM_RESET = 15'd16384;

   typedef struct packed {
      logic [DIM_W-1:0] max_width;
      logic [DIM_W-1:0] max_height;
      logic             header_only;
   } cfg_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [2:0]       status;
      logic [DIM_W-1:0] col_or_width;
      logic [DIM_W-1:0] row_or_height;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [7:0]       alpha;
      logic [5:0]       bit_depth;
      logic             indexed;
      logic             last;
   } result_type;

   // One queue entry holds every result that one byte causes
   typedef struct packed {
      logic       two;
      result_type res0;
      result_type res1;
   } entry_type;

   function automatic result_type make_final(input logic [2:0] status);
      result_type r;
      r        = '0;
      r.kind   = KIND_STATUS;
      r.status = status;
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: sv/srsd_queue.sv
// ----------------------------------------------------------------------------
// srsd_queue: result queue between parser and output stage
// Small register queue; one write and one read per cycle when not full/empty.
// ----------------------------------------------------------------------------
`default_nettype none

module srsd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr,
   input  wire srsd_pkg::entry_type wr_data,
   output logic                    full,
   input  wire logic               rd,
   output srsd_pkg::entry_type     rd_data,
   output logic                    empty
);
   import srsd_pkg::*;

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [QADDR_W-1:0] head_ff, head_in;
   logic [QADDR_W-1:0] tail_ff, tail_in;
   logic [QADDR_W:0]   count_ff, count_in;

   // Flags
   assign full    = (count_ff == (QADDR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[head_ff];

   // Advance pointers
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (wr) begin
         tail_in = tail_ff + 1'b1;
      end
      if (rd) begin
         head_in = head_ff + 1'b1;
      end
      if (wr && !rd) begin
         count_in = count_ff + 1'b1;
      end else if (rd && !wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Store entry
   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[tail_ff] <= wr_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !wr)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !rd)
      else $error("queue read while empty");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (wr && !rd) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a write");

endmodule

`default_nettype wire

FILE: sv/srsd_front.sv
// ----------------------------------------------------------------------------
// srsd_front: byte parser of the raster stream decoder
// Collects the header, skips the colormap, assembles pixels and writes the
// results of each byte as one entry into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module srsd_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire srsd_pkg::cfg_type   cfg,
   input  wire logic                push,
   input  wire logic [7:0]          data_byte,
   input  wire logic                end_of_file,
   input  wire logic                q_full,
   output logic                     q_wr,
   output srsd_pkg::entry_type      q_data
);
   import srsd_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_MAP,
      PH_PIXELS,
      PH_DRAIN
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [4:0]       offset_ff, offset_in;
   logic [23:0]      word_ff, word_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [5:0]       depth_ff, depth_in;
   logic [1:0]       bpp_m1_ff, bpp_m1_in;
   logic [16:0]      row_len_ff, row_len_in;
   logic [31:0]      map_ff, map_in;
   logic [DIM_W-1:0] col_ff, col_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic [16:0]      row_byte_ff, row_byte_in;
   logic [1:0]       sub_ff, sub_in;
   logic [23:0]      pix_ff, pix_in;
   logic             bad_magic_ff, bad_magic_in;
   logic             bad_dims_ff, bad_dims_in;
   logic             unsupp_ff, unsupp_in;
   logic             idx_ff, idx_in;

   logic             accept;
   logic [31:0]      w;
   logic [16:0]      stride;
   logic             first_v, second_v;
   result_type       first_r, second_r;

   assign accept = push && !q_full;
   assign w      = {word_ff, data_byte};
   assign stride = row_len_ff + {16'd0, row_len_ff[0]};

   // Classify the byte and build its results
   always_comb begin
      phase_in     = phase_ff;
      offset_in    = offset_ff;
      word_in      = word_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      depth_in     = depth_ff;
      bpp_m1_in    = bpp_m1_ff;
      row_len_in   = row_len_ff;
      map_in       = map_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      row_byte_in  = row_byte_ff;
      sub_in       = sub_ff;
      pix_in       = pix_ff;
      bad_magic_in = bad_magic_ff;
      bad_dims_in  = bad_dims_ff;
      unsupp_in    = unsupp_ff;
      idx_in       = idx_ff;
      first_v      = 1'b0;
      first_r      = '0;
      second_v     = 1'b0;
      second_r     = '0;
      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               word_in = w[23:0];
               // Start of a header clears the flags
               if (offset_ff == '0) begin
                  bad_magic_in = 1'b0;
                  bad_dims_in  = 1'b0;
                  unsupp_in    = 1'b0;
                  idx_in       = 1'b0;
               end
               // Check each completed header word
               if (offset_ff[1:0] == 2'd3) begin
                  case (offset_ff[4:2])
                     3'd0: bad_magic_in = (w != RAS_MAGIC);
                     3'd1: begin
                        if (w == '0 || w > {17'd0, cfg.max_width} || w > MAX_DIM) begin
                           bad_dims_in = 1'b1;
                        end
                        width_in = w[DIM_W-1:0];
                     end
                     3'd2: begin
                        if (w == '0 || w > {17'd0, cfg.max_height} || w > MAX_DIM) begin
                           bad_dims_in = 1'b1;
                        end
                        height_in = w[DIM_W-1:0];
                     end
                     3'd3: begin
                        depth_in = (w > {26'd0, DEPTH_CLIP}) ? DEPTH_CLIP : w[5:0];
                        case (w)
                           32'd8: begin
                              bpp_m1_in  = 2'd0;
                              row_len_in = {2'd0, width_ff};
                           end
                           32'd24: begin
                              bpp_m1_in  = 2'd2;
                              row_len_in = {2'd0, width_ff} + {1'b0, width_ff, 1'b0};
                           end
                           32'd32: begin
                              bpp_m1_in  = 2'd3;
                              row_len_in = {width_ff, 2'd0};
                           end
                           default: begin
                              unsupp_in = 1'b1;
                           end
                        endcase
                     end
                     3'd5: begin
                        if (w > 32'd1) begin
                           unsupp_in = 1'b1;
                        end
                     end
                     3'd6: idx_in = (w != '0);
                     3'd7: map_in = w;
                     default: ;
                  endcase
               end
               if (offset_ff != HDR_LAST) begin
                  offset_in = offset_ff + 1'b1;
                  if (end_of_file) begin
                     offset_in = '0;
                     second_v  = 1'b1;
                     second_r  = make_final(ST_TRUNCATED);
                  end
               end else begin
                  // Header complete
                  offset_in = '0;
                  if (bad_magic_in) begin
                     second_v = 1'b1;
                     second_r = make_final(ST_BAD_MAGIC);
                  end else if (bad_dims_in) begin
                     second_v = 1'b1;
                     second_r = make_final(ST_BAD_DIMS);
                  end else begin
                     first_v               = 1'b1;
                     first_r.kind          = KIND_INFO;
                     first_r.col_or_width  = width_ff;
                     first_r.row_or_height = height_ff;
                     first_r.bit_depth     = depth_ff;
                     first_r.indexed       = idx_ff;
                     if (cfg.header_only) begin
                        second_v = 1'b1;
                        second_r = make_final(ST_OK);
                     end else if (unsupp_ff) begin
                        second_v = 1'b1;
                        second_r = make_final(ST_UNSUPP);
                     end else begin
                        col_in      = '0;
                        row_in      = '0;
                        row_byte_in = '0;
                        sub_in      = '0;
                        pix_in      = '0;
                        phase_in    = (w != '0) ? PH_MAP : PH_PIXELS;
                        if (end_of_file) begin
                           second_v = 1'b1;
                           second_r = make_final(ST_TRUNCATED);
                        end
                     end
                  end
                  if (second_v) begin
                     phase_in = end_of_file ? PH_HEADER : PH_DRAIN;
                  end
               end
            end
            PH_MAP: begin
               // Drop colormap bytes
               map_in = map_ff - 1'b1;
               if (map_in == '0) begin
                  phase_in = PH_PIXELS;
               end
               if (end_of_file) begin
                  second_v = 1'b1;
                  second_r = make_final(ST_TRUNCATED);
                  phase_in = PH_HEADER;
               end
            end
            PH_PIXELS: begin
               // Assemble pixel bytes; row padding is dropped
               if (row_byte_ff < row_len_ff) begin
                  case (sub_ff)
                     2'd0:    pix_in = {data_byte, 16'd0};
                     2'd1:    pix_in = {pix_ff[23:16], data_byte, pix_ff[7:0]};
                     2'd2:    pix_in = {pix_ff[23:8], data_byte};
                     default: pix_in = pix_ff;
                  endcase
                  if (sub_ff == bpp_m1_ff) begin
                     first_v               = 1'b1;
                     first_r.kind          = KIND_PIXEL;
                     first_r.col_or_width  = col_ff;
                     first_r.row_or_height = row_ff;
                     first_r.red           = pix_in[23:16];
                     if (bpp_m1_ff == 2'd0) begin
                        first_r.green = pix_in[23:16];
                        first_r.blue  = pix_in[23:16];
                     end else begin
                        first_r.green = pix_in[15:8];
                        first_r.blue  = pix_in[7:0];
                     end
                     first_r.alpha = (bpp_m1_ff == 2'd3) ? data_byte : ALPHA_FULL;
                     col_in        = col_ff + 1'b1;
                     sub_in        = '0;
                  end else begin
                     sub_in = sub_ff + 1'b1;
                  end
               end
               row_byte_in = row_byte_ff + 1'b1;
               if (row_byte_in == stride) begin
                  row_byte_in = '0;
                  col_in      = '0;
                  sub_in      = '0;
                  row_in      = row_ff + 1'b1;
                  if (row_in == height_ff) begin
                     second_v = 1'b1;
                     second_r = make_final(ST_OK);
                     phase_in = end_of_file ? PH_HEADER : PH_DRAIN;
                  end
               end
               if (end_of_file && !second_v) begin
                  second_v = 1'b1;
                  second_r = make_final(ST_TRUNCATED);
                  phase_in = PH_HEADER;
               end
            end
            default: begin
               // Ignore bytes up to the end of the file
               if (end_of_file) begin
                  phase_in  = PH_HEADER;
                  offset_in = '0;
               end
            end
         endcase
      end
   end

   // Pack the results of this byte into one entry
   always_comb begin
      q_data = '0;
      q_wr   = accept && (first_v || second_v);
      if (first_v) begin
         q_data.res0 = first_r;
         if (second_v) begin
            q_data.two       = 1'b1;
            q_data.res1      = second_r;
            q_data.res1.last = 1'b1;
         end else begin
            q_data.res0.last = 1'b1;
         end
      end else begin
         q_data.res0      = second_r;
         q_data.res0.last = 1'b1;
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         offset_ff    <= '0;
         bad_magic_ff <= 1'b0;
         bad_dims_ff  <= 1'b0;
         unsupp_ff    <= 1'b0;
         idx_ff       <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         row_byte_ff  <= '0;
         sub_ff       <= '0;
         map_ff       <= '0;
      end else begin
         phase_ff     <= phase_in;
         offset_ff    <= offset_in;
         bad_magic_ff <= bad_magic_in;
         bad_dims_ff  <= bad_dims_in;
         unsupp_ff    <= unsupp_in;
         idx_ff       <= idx_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         row_byte_ff  <= row_byte_in;
         sub_ff       <= sub_in;
         map_ff       <= map_in;
      end
      word_ff    <= word_in;
      width_ff   <= width_in;
      height_ff  <= height_in;
      depth_ff   <= depth_in;
      bpp_m1_ff  <= bpp_m1_in;
      row_len_ff <= row_len_in;
      pix_ff     <= pix_in;
   end

endmodule

`default_nettype wire

FILE: sv/srsd_back.sv
// ----------------------------------------------------------------------------
// srsd_back: output stage of the raster stream decoder
// Takes entries from the result queue and hands out their results one at a
// time on the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module srsd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire srsd_pkg::entry_type q_data,
   input  wire logic                q_empty,
   output logic                     q_rd,
   input  wire logic                pop,
   output logic                     empty,
   output srsd_pkg::result_type     result
);
   import srsd_pkg::*;

   logic      valid_ff, valid_in;
   logic      sel_ff, sel_in;
   entry_type entry_ff;
   logic      done;

   assign empty  = !valid_ff;
   assign result = sel_ff ? entry_ff.res1 : entry_ff.res0;
   assign done   = (sel_ff == entry_ff.two);
   assign q_rd   = (!valid_ff || (pop && done)) && !q_empty;

   // Advance through the held entry, then reload
   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      if (q_rd) begin
         valid_in = 1'b1;
         sel_in   = 1'b0;
      end else if (pop && valid_ff) begin
         if (done) begin
            valid_in = 1'b0;
         end else begin
            sel_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
      if (q_rd) begin
         entry_ff <= q_data;
      end
   end

endmodule

`default_nettype wire

FILE: sv/sun_raster_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// sun_raster_stream_decoder_core: streaming raster file decoder
// Parses header, colormap and pixel bytes and returns RGBA, info and status
// results through a result queue.
// ----------------------------------------------------------------------------
// Throughput: one byte accepted per cycle unless req_full is high; one result
//   delivered per cycle while results are waiting. A byte's results are
//   written into the result queue, then loaded into the output stage.
// A byte with two results holds the output stage for two pops; full rises
//   when the four-entry result queue fills.
// Reset: synchronous; clears the parser to the header phase, empties the
//   queue and sets the limits to 16384 and header_only to 0.
`default_nettype none

module sun_raster_stream_decoder_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   output logic                            req_full,
   input  wire logic [7:0]                 req_data_byte,
   input  wire logic                       req_end_of_file,
   output logic                            rsp_empty,
   input  wire logic                       rsp_pop,
   output logic [1:0]                      rsp_kind,
   output logic [2:0]                      rsp_status,
   output logic [srsd_pkg::DIM_W-1:0]      rsp_col_or_width,
   output logic [srsd_pkg::DIM_W-1:0]      rsp_row_or_height,
   output logic [7:0]                      rsp_red,
   output logic [7:0]                      rsp_green,
   output logic [7:0]                      rsp_blue,
   output logic [7:0]                      rsp_alpha,
   output logic [5:0]                      rsp_bit_depth,
   output logic                            rsp_indexed,
   output logic                            rsp_last,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [1:0]                 csr_index,
   input  wire logic [srsd_pkg::DIM_W-1:0] csr_data
);
   import srsd_pkg::*;

   cfg_type    cfg_ff;
   logic       q_wr, q_rd, q_full, q_empty;
   entry_type  q_wr_data, q_rd_data;
   result_type result;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_width   <= MAX_DIM_RESET;
         cfg_ff.max_height  <= MAX_DIM_RESET;
         cfg_ff.header_only <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_WIDTH:   cfg_ff.max_width   <= csr_data;
            CSR_MAX_HEIGHT:  cfg_ff.max_height  <= csr_data;
            CSR_HEADER_ONLY: cfg_ff.header_only <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign req_full = q_full;

   srsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .push        (req_push),
      .data_byte   (req_data_byte),
      .end_of_file (req_end_of_file),
      .q_full      (q_full),
      .q_wr        (q_wr),
      .q_data      (q_wr_data)
   );

   srsd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (q_wr),
      .wr_data (q_wr_data),
      .full    (q_full),
      .rd      (q_rd),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   srsd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_data  (q_rd_data),
      .q_empty (q_empty),
      .q_rd    (q_rd),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .result  (result)
   );

   // Drive result ports
   assign rsp_kind          = result.kind;
   assign rsp_status        = result.status;
   assign rsp_col_or_width  = result.col_or_width;
   assign rsp_row_or_height = result.row_or_height;
   assign rsp_red           = result.red;
   assign rsp_green         = result.green;
   assign rsp_blue          = result.blue;
   assign rsp_alpha         = result.alpha;
   assign rsp_bit_depth     = result.bit_depth;
   assign rsp_indexed       = result.indexed;
   assign rsp_last          = result.last;

endmodule

`default_nettype wire
